>>> rtl/polyphonic_voice_mixer_core_defines.svh
// assertion helpers for the voice mixer core
`ifndef POLYPHONIC_VOICE_MIXER_CORE_DEFINES_SVH
`define POLYPHONIC_VOICE_MIXER_CORE_DEFINES_SVH

// condition holds in the same cycle
`define PVM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define PVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pvm_pkg.sv
package pvm_pkg;

	localparam int MAX_VOICES = 16;
	localparam int VIDX_W = $clog2(MAX_VOICES);
	localparam int CNT_W = 5;
	localparam int SINE_DEPTH = 256;
	localparam int SINE_AW = $clog2(SINE_DEPTH);
	localparam int PADDR_W = 4;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [16:0] OSC_ONE = 17'sd32768;
	localparam logic [16:0] ENV_ONE = 17'd65536;

	// register map
	typedef enum logic [1:0] {
		REG_WAVEFORM = 2'd0,
		REG_DUTY     = 2'd1,
		REG_ATTACK   = 2'd2,
		REG_RELEASE  = 2'd3
	} reg_idx_t;

	// oscillator shapes
	localparam logic [1:0] WAVE_SINE     = 2'd0;
	localparam logic [1:0] WAVE_SQUARE   = 2'd1;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

	// request actions
	localparam logic ACT_NOTE_ON = 1'b0;
	localparam logic ACT_TICK    = 1'b1;

	typedef struct packed {
		logic [31:0] vstart;
		logic [31:0] vstop;
		logic [31:0] vstep;
		logic [8:0]  vlevel;
	} voice_t;

	typedef logic [15:0] sine_tbl_t [SINE_DEPTH];

	// quarter sine in Q15, Taylor series in Q30 worked out at elaboration
	function automatic sine_tbl_t build_sine();
		sine_tbl_t tbl;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned val;
		longint sum;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			x = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = (term * x2) >> 30;
				case (n)
					1: term = term / 6;
					2: term = term / 20;
					3: term = term / 42;
					4: term = term / 72;
					5: term = term / 110;
					default: term = term / 156;
				endcase
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			val = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
			if (val > 32768) begin
				val = 32768;
			end
			tbl[k] = val[15:0];
		end
		return tbl;
	endfunction

	localparam sine_tbl_t SINE_TBL = build_sine();

endpackage

>>> rtl/pvm_ifs.sv
interface pvm_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] sample_time;
	logic [31:0] note_end;
	logic [31:0] phase_step;
	logic [8:0]  velocity;
	modport source(output valid, action, sample_time, note_end, phase_step, velocity,
		input ready);
	modport sink(input valid, action, sample_time, note_end, phase_step, velocity,
		output ready);
endinterface

interface pvm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic [4:0]         active_voices;
	logic               note_dropped;
	modport source(output valid, mixed_sample, active_voices, note_dropped, input ready);
	modport sink(input valid, mixed_sample, active_voices, note_dropped, output ready);
endinterface

>>> rtl/polyphonic_voice_mixer_core.sv
// Polyphonic voice mixer. A note_on request stores a voice in the lowest free slot of a
// sixteen-entry voice memory; with every slot taken it is dropped and flagged. A tick
// request walks the slots one after another through a single read port of that memory:
// a free slot is skipped, an expired voice is freed and a sounding voice is mixed in; inside
// an attack or release ramp a shared one-bit-per-cycle divider works out the ramp level.
// The sum is then clamped and scaled before the hand-off. One request is worked on at a
// time; the next is taken while the previous result still waits at the output register.
`include "polyphonic_voice_mixer_core_defines.svh"

module polyphonic_voice_mixer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	pvm_in_if.sink                      in,
	pvm_out_if.source                   out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pvm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_READ  = 12'b0000_0000_0010,
		ST_TEST  = 12'b0000_0000_0100,
		ST_PHASE = 12'b0000_0000_1000,
		ST_DIV   = 12'b0000_0001_0000,
		ST_OSC   = 12'b0000_0010_0000,
		ST_MUL1  = 12'b0000_0100_0000,
		ST_MUL2  = 12'b0000_1000_0000,
		ST_ACC   = 12'b0001_0000_0000,
		ST_CLAMP = 12'b0010_0000_0000,
		ST_SCALE = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t st_q;

	logic [1:0]  waveform_q;
	logic [6:0]  duty_q;
	logic [19:0] attack_q;
	logic [19:0] release_q;

	logic [pvm_pkg::MAX_VOICES-1:0] valid_q;
	pvm_pkg::voice_t mem_q [pvm_pkg::MAX_VOICES];
	pvm_pkg::voice_t rdata_q;
	logic [pvm_pkg::VIDX_W-1:0] vidx_q;
	logic [31:0] time_q;
	logic [31:0] t_q;
	logic [31:0] len_q;
	logic [31:0] p_q;
	logic [16:0] env_q;
	logic        use_div_q;
	logic        inv_q;
	logic [19:0] rem_q;
	logic [19:0] dvsr_q;
	logic [15:0] quo_q;
	logic [3:0]  dcnt_q;
	logic signed [16:0] osc_q;
	logic signed [34:0] prod1_q;
	logic signed [44:0] prod2_q;
	logic signed [47:0] sum_q;
	logic        neg_q;
	logic [39:0] mag_q;
	logic signed [15:0] res_sample_q;
	logic        res_drop_q;

	logic out_valid_q;
	logic signed [15:0] out_sample_q;
	logic [4:0]  out_count_q;
	logic        out_drop_q;

	logic in_acc;
	logic apb_wr;
	logic last_voice;
	logic free_any;
	logic [pvm_pkg::VIDX_W-1:0] free_idx;
	logic gone;
	logic [31:0] rel_t;
	logic [20:0] rem2;
	logic rem_ge;
	logic signed [16:0] osc_val;
	logic [pvm_pkg::SINE_AW-1:0] sidx;
	logic [16:0] smag;
	logic [38:0] sq_lhs;
	logic [31:0] tri_d;
	logic [33:0] tri_four;
	logic [33:0] tri_mag;
	logic [47:0] abs_sum;
	logic [54:0] scaled;
	logic out_free;

	assign in_acc = in.valid & in.ready;
	assign in.ready = (st_q == ST_IDLE);
	assign apb_wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign last_voice = (vidx_q == pvm_pkg::VIDX_W'(pvm_pkg::MAX_VOICES - 1));
	assign out_free = !out_valid_q || out.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= pvm_pkg::WAVE_SINE;
			duty_q <= 7'd50;
			attack_q <= '0;
			release_q <= '0;
		end else if (apb_wr) begin
			unique case (pvm_pkg::reg_idx_t'(paddr[3:2]))
				pvm_pkg::REG_WAVEFORM: waveform_q <= pwdata[1:0];
				pvm_pkg::REG_DUTY:     duty_q <= pwdata[6:0];
				pvm_pkg::REG_ATTACK:   attack_q <= pwdata[19:0];
				pvm_pkg::REG_RELEASE:  release_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (pvm_pkg::reg_idx_t'(paddr[3:2]))
			pvm_pkg::REG_WAVEFORM: prdata = {30'd0, waveform_q};
			pvm_pkg::REG_DUTY:     prdata = {25'd0, duty_q};
			pvm_pkg::REG_ATTACK:   prdata = {12'd0, attack_q};
			pvm_pkg::REG_RELEASE:  prdata = {12'd0, release_q};
			default:               prdata = '0;
		endcase
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = pvm_pkg::MAX_VOICES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = pvm_pkg::VIDX_W'(i);
			end
		end
	end
	assign free_any = ~&valid_q;

	// voice expiry: end plus release without wrap
	assign gone = ({1'b0, rdata_q.vstop} + {13'd0, release_q}) <= {1'b0, time_q};
	assign rel_t = t_q - len_q;

	// divider step
	assign rem2 = {rem_q, 1'b0};
	assign rem_ge = rem2 >= {1'b0, dvsr_q};

	// oscillator
	always_comb begin
		sidx = p_q[29 -: pvm_pkg::SINE_AW];
		if (p_q[30]) begin
			if (sidx == '0) begin
				smag = 17'd32768;
			end else begin
				smag = {1'b0, pvm_pkg::SINE_TBL[-sidx]};
			end
		end else begin
			smag = {1'b0, pvm_pkg::SINE_TBL[sidx]};
		end
		sq_lhs = {7'd0, p_q} * 39'd100;
		tri_d = p_q[31] ? (p_q - 32'h8000_0000) : (32'h8000_0000 - p_q);
		tri_four = {tri_d, 2'b00};
		tri_mag = (tri_four[33:32] != 2'b00) ? (tri_four - 34'h1_0000_0000)
			: (34'h1_0000_0000 - tri_four);
		case (waveform_q)
			pvm_pkg::WAVE_SINE: osc_val = p_q[31] ? -$signed(smag) : $signed(smag);
			pvm_pkg::WAVE_SQUARE: osc_val = (sq_lhs < {duty_q, 32'd0}) ? pvm_pkg::OSC_ONE
				: -pvm_pkg::OSC_ONE;
			pvm_pkg::WAVE_TRIANGLE: begin
				if (tri_four[33:32] != 2'b00) begin
					osc_val = $signed({1'b0, tri_mag[32:17]});
				end else begin
					osc_val = -$signed({1'b0, tri_mag[32:17]});
				end
			end
			default: osc_val = '0;
		endcase
	end

	assign abs_sum = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
	assign scaled = {15'd0, mag_q} * 55'd32767;

	// voice memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && in.action == pvm_pkg::ACT_NOTE_ON && free_any) begin
			mem_q[free_idx] <= '{vstart: in.sample_time, vstop: in.note_end,
				vstep: in.phase_step, vlevel: in.velocity};
		end
		if (st_q == ST_READ) begin
			rdata_q <= mem_q[vidx_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid_q <= '0;
			vidx_q <= '0;
			dcnt_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in.action == pvm_pkg::ACT_NOTE_ON) begin
							if (free_any) begin
								valid_q[free_idx] <= 1'b1;
							end
							st_q <= ST_DONE;
						end else begin
							vidx_q <= '0;
							st_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (valid_q[vidx_q]) begin
						st_q <= ST_TEST;
					end else if (last_voice) begin
						st_q <= ST_CLAMP;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				ST_TEST: begin
					if (gone) begin
						valid_q[vidx_q] <= 1'b0;
						if (last_voice) begin
							st_q <= ST_CLAMP;
						end else begin
							vidx_q <= vidx_q + 1'b1;
							st_q <= ST_READ;
						end
					end else begin
						st_q <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					dcnt_q <= '0;
					if ((attack_q != '0 && t_q < {12'd0, attack_q})
						|| (t_q >= len_q && rel_t < {12'd0, release_q})) begin
						st_q <= ST_DIV;
					end else begin
						st_q <= ST_OSC;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 4'd15) begin
						st_q <= ST_OSC;
					end
				end
				ST_OSC:  st_q <= ST_MUL1;
				ST_MUL1: st_q <= ST_MUL2;
				ST_MUL2: st_q <= ST_ACC;
				ST_ACC: begin
					if (last_voice) begin
						st_q <= ST_CLAMP;
					end else begin
						vidx_q <= vidx_q + 1'b1;
						st_q <= ST_READ;
					end
				end
				ST_CLAMP: st_q <= ST_SCALE;
				ST_SCALE: st_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				time_q <= in.sample_time;
				sum_q <= '0;
				res_sample_q <= '0;
				res_drop_q <= !free_any;
			end
			ST_TEST: begin
				t_q <= time_q - rdata_q.vstart;
				len_q <= rdata_q.vstop - rdata_q.vstart;
			end
			ST_PHASE: begin
				p_q <= rdata_q.vstep * t_q;
				quo_q <= '0;
				if (attack_q != '0 && t_q < {12'd0, attack_q}) begin
					use_div_q <= 1'b1;
					inv_q <= 1'b0;
					rem_q <= t_q[19:0];
					dvsr_q <= attack_q;
				end else if (t_q < len_q) begin
					use_div_q <= 1'b0;
					env_q <= pvm_pkg::ENV_ONE;
				end else if (rel_t < {12'd0, release_q}) begin
					use_div_q <= 1'b1;
					inv_q <= 1'b1;
					rem_q <= rel_t[19:0];
					dvsr_q <= release_q;
				end else begin
					use_div_q <= 1'b0;
					env_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? 20'(rem2 - {1'b0, dvsr_q}) : rem2[19:0];
				quo_q <= {quo_q[14:0], rem_ge};
			end
			ST_OSC: begin
				osc_q <= osc_val;
				if (use_div_q) begin
					env_q <= inv_q ? (pvm_pkg::ENV_ONE - {1'b0, quo_q}) : {1'b0, quo_q};
				end
			end
			ST_MUL1: prod1_q <= osc_q * $signed({1'b0, env_q});
			ST_MUL2: prod2_q <= prod1_q * $signed({1'b0, rdata_q.vlevel});
			ST_ACC:  sum_q <= sum_q + 48'(prod2_q);
			ST_CLAMP: begin
				neg_q <= sum_q[47];
				mag_q <= (abs_sum > 48'h80_0000_0000) ? 40'h80_0000_0000 : abs_sum[39:0];
			end
			ST_SCALE: begin
				res_drop_q <= 1'b0;
				res_sample_q <= neg_q ? -$signed(scaled[54:39]) : $signed(scaled[54:39]);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE && out_free) begin
			out_sample_q <= res_sample_q;
			out_count_q <= pvm_pkg::CNT_W'($countones(valid_q));
			out_drop_q <= res_drop_q;
		end
	end

	assign out.valid = out_valid_q;
	assign out.mixed_sample = out_sample_q;
	assign out.active_voices = out_count_q;
	assign out.note_dropped = out_drop_q;

	// checks
	`PVM_ASSERT_NEXT(a_full_drop, in_acc && in.action == pvm_pkg::ACT_NOTE_ON && &valid_q, valid_q == $past(valid_q), "note on a full table changed the voices")
	`PVM_ASSERT_NEXT(a_note_add, in_acc && in.action == pvm_pkg::ACT_NOTE_ON && !(&valid_q), $countones(valid_q) == $countones($past(valid_q)) + 1, "note on did not add one voice")
	`PVM_ASSERT_NEXT(a_walk_no_add, st_q != ST_IDLE, (valid_q & ~$past(valid_q)) == '0, "voice added during a walk")
	`PVM_ASSERT_NOW(a_sample_range, out_valid_q, out_sample_q != 16'sh8000, "mixed sample out of range")

endmodule

>>> verif/polyphonic_voice_mixer_core_tb.sv
module polyphonic_voice_mixer_core_tb;

	typedef struct {
		logic signed [15:0] smp;
		logic [4:0]         cnt;
		logic               drop;
	} mix_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [pvm_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pvm_in_if  req_if();
	pvm_out_if res_if();

	polyphonic_voice_mixer_core dut (
		.clk(clk), .arst_n(arst_n), .in(req_if), .out(res_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [15:0] quarter_sine [pvm_pkg::SINE_DEPTH];
	logic [31:0] v_begin [pvm_pkg::MAX_VOICES];
	logic [31:0] v_stop [pvm_pkg::MAX_VOICES];
	logic [31:0] v_rate [pvm_pkg::MAX_VOICES];
	logic [8:0]  v_gain [pvm_pkg::MAX_VOICES];
	logic        v_busy [pvm_pkg::MAX_VOICES];
	logic [1:0]  shape;
	logic [6:0]  duty;
	logic [19:0] attack_len;
	logic [19:0] release_len;

	mix_result_t pending_mix[$];
	int unsigned errors;
	int unsigned requests_sent;
	int unsigned results_seen;
	int unsigned drops_seen;
	int unsigned cfg_writes;
	logic [31:0] now_t;
	bit          long_hold;

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void build_quarter_sine();
		longint unsigned x, x2, term, val;
		longint sum;
		for (int k = 0; k < pvm_pkg::SINE_DEPTH; k++) begin
			x = (64'd1686629713 * longint'(k)) / pvm_pkg::SINE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum -= longint'(term);
				end else begin
					sum += longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			val = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
			if (val > 32768) begin
				val = 32768;
			end
			quarter_sine[k] = val[15:0];
		end
	endfunction

	function automatic longint osc_level(logic [31:0] p);
		longint unsigned d, four, idx, m;
		longint mag;
		case (shape)
			pvm_pkg::WAVE_SINE: begin
				idx = (longint'(p[29:0]) * pvm_pkg::SINE_DEPTH) >> 30;
				if (p[30]) begin
					m = pvm_pkg::SINE_DEPTH - idx;
					mag = (m >= pvm_pkg::SINE_DEPTH) ? 32768 : longint'(quarter_sine[m]);
				end else begin
					mag = longint'(quarter_sine[idx]);
				end
				return p[31] ? -mag : mag;
			end
			pvm_pkg::WAVE_SQUARE: begin
				return (longint'(p) * 100 < (longint'(duty) << 32)) ? 32768 : -32768;
			end
			pvm_pkg::WAVE_TRIANGLE: begin
				d = (p >= 32'h8000_0000) ? longint'(p) - 64'h8000_0000
					: 64'h8000_0000 - longint'(p);
				four = 4 * d;
				if (four >= (64'd1 << 32)) begin
					return longint'((four - (64'd1 << 32)) >> 17);
				end
				return -longint'(((64'd1 << 32) - four) >> 17);
			end
			default: return 0;
		endcase
	endfunction

	function automatic longint env_level(logic [31:0] t, logic [31:0] len);
		logic [31:0] r;
		if (attack_len != 0 && t < attack_len) begin
			return (longint'(t) << 16) / longint'(attack_len);
		end
		if (t < len) begin
			return 65536;
		end
		r = t - len;
		if (r < release_len) begin
			return 65536 - ((longint'(r) << 16) / longint'(release_len));
		end
		return 0;
	endfunction

	// works out the result of one request and updates the voice table
	function automatic mix_result_t mix_predict(logic act, logic [31:0] stamp,
		logic [31:0] stop, logic [31:0] rate, logic [8:0] gain);
		mix_result_t res;
		bit placed;
		longint sum;
		longint unsigned mag;
		logic [31:0] t, p;
		int cnt;
		res.smp = '0;
		res.drop = 1'b0;
		if (act == pvm_pkg::ACT_NOTE_ON) begin
			placed = 0;
			for (int i = 0; i < pvm_pkg::MAX_VOICES; i++) begin
				if (!v_busy[i] && !placed) begin
					v_busy[i] = 1'b1;
					v_begin[i] = stamp;
					v_stop[i] = stop;
					v_rate[i] = rate;
					v_gain[i] = gain;
					placed = 1;
				end
			end
			res.drop = !placed;
		end else begin
			sum = 0;
			for (int i = 0; i < pvm_pkg::MAX_VOICES; i++) begin
				if (!v_busy[i]) begin
					continue;
				end
				// end plus release taken without wrap
				if ({1'b0, v_stop[i]} + {13'd0, release_len} <= {1'b0, stamp}) begin
					v_busy[i] = 1'b0;
					continue;
				end
				t = stamp - v_begin[i];
				p = v_rate[i] * t;
				sum += osc_level(p) * env_level(t, v_stop[i] - v_begin[i])
					* longint'(v_gain[i]);
			end
			if (sum > (64'sd1 <<< 39)) begin
				sum = 64'sd1 <<< 39;
			end
			if (sum < -(64'sd1 <<< 39)) begin
				sum = -(64'sd1 <<< 39);
			end
			mag = (sum < 0) ? -sum : sum;
			mag = (mag * 32767) >> 39;
			res.smp = 16'((sum < 0) ? -longint'(mag) : longint'(mag));
		end
		cnt = 0;
		for (int i = 0; i < pvm_pkg::MAX_VOICES; i++) begin
			cnt += v_busy[i];
		end
		res.cnt = cnt[4:0];
		return res;
	endfunction

	// sends one request after a random gap and predicts its result
	task automatic send_req(logic act, logic [31:0] stamp, logic [31:0] stop = 0,
		logic [31:0] rate = 0, logic [8:0] gain = 0);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.sample_time <= stamp;
		req_if.note_end <= stop;
		req_if.phase_step <= rate;
		req_if.velocity <= gain;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
		pending_mix.insert(pending_mix.size(), mix_predict(act, stamp, stop, rate, gain));
		requests_sent++;
	endtask

	task automatic note_on(logic [31:0] stamp, logic [31:0] len, logic [31:0] rate,
		logic [8:0] gain);
		send_req(pvm_pkg::ACT_NOTE_ON, stamp, stamp + len, rate, gain);
	endtask

	task automatic tick(logic [31:0] stamp);
		send_req(pvm_pkg::ACT_TICK, stamp);
	endtask

	// waits until every expected result is back, then lets the block settle
	task automatic drain();
		req_if.valid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(pvm_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pvm_pkg::PADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			pvm_pkg::REG_WAVEFORM: shape = value[1:0];
			pvm_pkg::REG_DUTY:     duty = value[6:0];
			pvm_pkg::REG_ATTACK:   attack_len = value[19:0];
			default:               release_len = value[19:0];
		endcase
		cfg_writes++;
	endtask

	task automatic set_config(logic [31:0] w, logic [31:0] d, logic [31:0] a,
		logic [31:0] r);
		drain();
		write_reg(pvm_pkg::REG_WAVEFORM, w);
		write_reg(pvm_pkg::REG_DUTY, d);
		write_reg(pvm_pkg::REG_ATTACK, a);
		write_reg(pvm_pkg::REG_RELEASE, r);
	endtask

	// reset defaults, field extremes and wrap cases
	task automatic test_directed();
		note_on(32'd0, 32'd100, 32'h0100_0000, 9'd256);
		note_on(32'd0, 32'd0, 32'hFFFF_FFFF, 9'd511);
		note_on(32'hFFFF_FFF0, 32'h0000_0040, 32'h0000_0000, 9'd0);
		note_on(32'd50, 32'hFFFF_FFB0, 32'hAAAA_AAAA, 9'h155);
		tick(32'd0);
		tick(32'd10);
		tick(32'hFFFF_FFF8);
		tick(32'd40);
		tick(32'hFFFF_FFFF);
		set_config(32'(pvm_pkg::WAVE_SQUARE), 32'd0, 32'd0, 32'hF_FFFF);
		note_on(32'd0, 32'hFFFF_FFFF, 32'h4000_0000, 9'd256);
		tick(32'd1);
		tick(32'hFFFF_FFFF);
	endtask

	// every waveform including the unused code, duty extremes
	task automatic test_waveforms();
		logic [31:0] duties [4] = '{32'd0, 32'd100, 32'd127, 32'd37};
		for (int w = 0; w < 4; w++) begin
			set_config(32'(w), duties[w], 32'd3, 32'd5);
			now_t += 32'd100000;
			note_on(now_t, 32'd8, 32'h1234_5678, 9'd256);
			note_on(now_t + 2, 32'd4, 32'h0800_0000, 9'd128);
			for (int k = 0; k < 4; k++) begin
				tick(now_t + 32'(k * 3));
			end
			tick(now_t + 32'd1000);
		end
	endtask

	// table full, dropped notes, then one late tick frees everything
	task automatic test_table_full();
		set_config(32'(pvm_pkg::WAVE_TRIANGLE), 32'd50, 32'hF_FFFF, 32'd0);
		now_t += 32'd10000;
		tick(now_t);
		for (int i = 0; i < pvm_pkg::MAX_VOICES + 2; i++) begin
			note_on(now_t, 32'd20, $urandom, 9'd256);
		end
		tick(now_t + 32'd3);
		tick(now_t + 32'd100);
		now_t += 32'd100;
	endtask

	// random notes and ticks on a running clock under several settings
	task automatic test_random(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				note_on(now_t + $urandom_range(0, 40) - 20,
					($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300),
					$urandom, 9'($urandom_range(0, 511)));
			end else if (pick < 97) begin
				now_t += $urandom_range(0, 60);
				tick(now_t);
			end else begin
				tick($urandom);
			end
		end
	endtask

	// receiver holds off long while requests keep coming
	task automatic test_backpressure();
		long_hold = 1;
		for (int i = 0; i < 30; i++) begin
			if (i % 3 == 0) begin
				note_on(now_t, 32'd50, $urandom, 9'd200);
			end else begin
				now_t += 32'd5;
				tick(now_t);
			end
		end
		// sender pauses until all results are back
		drain();
		test_random(10);
	endtask

	// result ready with random stalls and one long hold-off
	initial begin
		int gap;
		bit held;
		held = 0;
		res_if.ready <= 1'b0;
		forever begin
			if (long_hold && !held) begin
				gap = 300;
				held = 1;
			end else begin
				gap = $urandom_range(0, 3);
				if ($urandom_range(0, 7) == 0) begin
					gap = 0;
				end
			end
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!(res_if.valid && res_if.ready && arst_n));
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		mix_result_t exp_r;
		if (arst_n && res_if.valid && res_if.ready) begin
			results_seen++;
			if (pending_mix.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_r = pending_mix.pop_front();
				if (res_if.mixed_sample !== exp_r.smp) begin
					$error("mixed_sample expected %0d got %0d", exp_r.smp, res_if.mixed_sample);
					errors++;
				end
				if (res_if.active_voices !== exp_r.cnt) begin
					$error("active_voices expected %0d got %0d", exp_r.cnt,
						res_if.active_voices);
					errors++;
				end
				if (res_if.note_dropped !== exp_r.drop) begin
					$error("note_dropped expected %0b got %0b", exp_r.drop,
						res_if.note_dropped);
					errors++;
				end
				if (exp_r.drop) begin
					drops_seen++;
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("** polyphonic_voice_mixer_core: FAILED **");
		$finish;
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = pvm_pkg::ACT_TICK;
		req_if.sample_time = '0;
		req_if.note_end = '0;
		req_if.phase_step = '0;
		req_if.velocity = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		requests_sent = 0;
		results_seen = 0;
		drops_seen = 0;
		cfg_writes = 0;
		long_hold = 0;
		now_t = 32'd1000;
		shape = pvm_pkg::WAVE_SINE;
		duty = 7'd50;
		attack_len = '0;
		release_len = '0;
		for (int i = 0; i < pvm_pkg::MAX_VOICES; i++) begin
			v_busy[i] = 1'b0;
		end
		build_quarter_sine();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_waveforms();
		test_table_full();
		set_config(32'(pvm_pkg::WAVE_SINE), 32'd50, 32'd0, 32'd0);
		test_random(90);
		set_config(32'(pvm_pkg::WAVE_SQUARE), 32'd25, 32'd20, 32'd40);
		test_random(90);
		set_config(32'(pvm_pkg::WAVE_TRIANGLE), 32'd100, 32'hF_FFFF, 32'd10);
		test_random(70);
		set_config(32'(pvm_pkg::WAVE_SINE), 32'd127, 32'd7, 32'hF_FFFF);
		test_random(70);
		test_backpressure();

		req_if.valid <= 1'b0;
		waited = 0;
		while (pending_mix.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (400) @(posedge clk);
		$display("run covered %0d requests, %0d results, %0d dropped notes",
			requests_sent, results_seen, drops_seen);
		$display("%0d register writes; all four waveforms, ramp extremes, full table, long stalls",
			cfg_writes);
		if (errors == 0 && pending_mix.size() == 0) begin
			$display("** polyphonic_voice_mixer_core: PASSED **");
		end else begin
			$display("** polyphonic_voice_mixer_core: FAILED **");
		end
		$finish;
	end

endmodule
